// File: sv/tsq_pkg.sv
// shared constants and types for the thick segment quad unit
package tsq_pkg;

    localparam int COORD_WIDTH_DEF = 13;
    localparam int OFFSET_FRAC_DEF = 8;
    localparam int THICK_W         = 10;
    localparam logic [THICK_W-1:0] THICK_RESET = THICK_W'(1);
    localparam int UNIT_FRAC       = 16;
    localparam int LEN_FRAC        = 8;
    localparam int Q_DEPTH         = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: sv/tsq_front.sv
// front end: endpoint differences and coincident-endpoint classification
module tsq_front import tsq_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic [6*COORD_WIDTH+2:0]      o_item
);
    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 zero;

    assign dx   = DW'(i_end_x) - DW'(i_start_x);
    assign dy   = DW'(i_end_y) - DW'(i_start_y);
    // both endpoints coincide: square instead of a stroked segment
    assign zero = (dx == '0) && (dy == '0);

    assign o_item = {i_start_x, i_start_y, i_end_x, i_end_y, dx, dy, zero};
endmodule

// File: sv/tsq_queue.sv
// short transaction queue between front end and back end
module tsq_queue import tsq_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);
    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:Q_DEPTH-1];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data          = r_mem[r_rp];
    assign o_status.full   = (r_cnt == CW'(Q_DEPTH));
    assign o_status.empty  = (r_cnt == '0);
endmodule

// File: sv/tsq_back.sv
// back end: length, unit vector, corner rounding and bounding-box offsets
module tsq_back import tsq_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int OFFSET_FRAC_BITS = OFFSET_FRAC_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [6*COORD_WIDTH+2:0]               i_item,
    input  t_q_status                              i_q_status,
    output logic                                   o_pop,
    input  logic [THICK_W-1:0]                     i_thick,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [COORD_WIDTH:0]            o_origin_x,
    output logic signed [COORD_WIDTH:0]            o_origin_y,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner0_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner0_dy,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner1_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner1_dy,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner2_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner2_dy,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner3_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner3_dy
);
    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int D2W = 2 * DW;
    localparam int VW  = D2W + 2 * LEN_FRAC;
    localparam int RW  = VW / 2;
    localparam int QW  = UNIT_FRAC + 1;
    localparam int NW  = RW + QW;
    localparam int SH  = UNIT_FRAC + 1;
    localparam int SW  = CW + 22;
    localparam int TW  = THICK_W + QW + 2;
    localparam int PW  = CW + 3;
    localparam int OW  = CW + 1 + OFFSET_FRAC_BITS;
    localparam int PLW = 6 * CW + 3;
    // field positions in the queued record
    localparam int P_DY = 1;
    localparam int P_DX = P_DY + DW;
    localparam int P_BY = P_DX + DW;
    localparam int P_BX = P_BY + CW;
    localparam int P_AY = P_BX + CW;
    localparam int P_AX = P_AY + CW;

    logic en;
    logic r_out_v;

    assign en      = !(r_out_v && i_stall);
    assign o_pop   = en && !i_q_status.empty;
    assign o_valid = r_out_v;

    // squared length
    logic signed [DW-1:0]  s0_dx;
    logic signed [DW-1:0]  s0_dy;
    logic signed [D2W-1:0] s0_sqx;
    logic signed [D2W-1:0] s0_sqy;
    logic [D2W-1:0]        s0_d2;

    assign s0_dx  = $signed(i_item[P_DX+DW-1:P_DX]);
    assign s0_dy  = $signed(i_item[P_DY+DW-1:P_DY]);
    assign s0_sqx = D2W'(s0_dx) * D2W'(s0_dy == s0_dy ? s0_dx : s0_dx);
    assign s0_sqy = D2W'(s0_dy) * D2W'(s0_dy);
    assign s0_d2  = $unsigned(s0_sqx) + $unsigned(s0_sqy);

    // square root pipeline, one root bit per stage
    logic [RW+1:0]  r_rem  [0:RW];
    logic [RW-1:0]  r_root [0:RW];
    logic [D2W-1:0] r_d2   [0:RW];
    logic [PLW-1:0] r_pl   [0:RW];
    logic           r_sv   [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_d2[0]   <= s0_d2;
            r_pl[0]   <= i_item;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [VW-1:0]  v;
        logic [RW+1:0]  rs;
        logic [RW+1:0]  tr;
        logic           ge;

        assign v  = {r_d2[k], {(2*LEN_FRAC){1'b0}}};
        assign rs = {r_rem[k][RW-1:0], v[VW-1-2*k -: 2]};
        assign tr = {r_root[k], 2'b01};
        assign ge = (rs >= tr);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k+1]  <= ge ? (rs - tr) : rs;
                r_root[k+1] <= {r_root[k][RW-2:0], ge};
                r_d2[k+1]   <= r_d2[k];
                r_pl[k+1]   <= r_pl[k];
            end
        end
    end

    // divider setup: round(|d| * 2^24 / L) = floor((|d| * 2^25 + L) / 2L)
    logic signed [DW-1:0] s1_dx;
    logic signed [DW-1:0] s1_dy;
    logic [DW-1:0]        s1_mx;
    logic [DW-1:0]        s1_my;

    assign s1_dx = $signed(r_pl[RW][P_DX+DW-1:P_DX]);
    assign s1_dy = $signed(r_pl[RW][P_DY+DW-1:P_DY]);
    assign s1_mx = s1_dx[DW-1] ? $unsigned(-s1_dx) : $unsigned(s1_dx);
    assign s1_my = s1_dy[DW-1] ? $unsigned(-s1_dy) : $unsigned(s1_dy);

    logic [NW-1:0]  r_nx  [0:QW];
    logic [NW-1:0]  r_ny  [0:QW];
    logic [QW-1:0]  r_qx  [0:QW];
    logic [QW-1:0]  r_qy  [0:QW];
    logic [RW:0]    r_den [0:QW];
    logic [PLW-1:0] r_dpl [0:QW];
    logic           r_dv  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_sv[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx[0]  <= (NW'(s1_mx[CW-1:0]) << (UNIT_FRAC + LEN_FRAC + 1)) + NW'(r_root[RW]);
            r_ny[0]  <= (NW'(s1_my[CW-1:0]) << (UNIT_FRAC + LEN_FRAC + 1)) + NW'(r_root[RW]);
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            r_den[0] <= {r_root[RW], 1'b0};
            r_dpl[0] <= r_pl[RW];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [NW-1:0] dsh;
        logic          gex;
        logic          gey;

        assign dsh = NW'(r_den[j]) << (QW - 1 - j);
        assign gex = (r_nx[j] >= dsh);
        assign gey = (r_ny[j] >= dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (en) begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nx[j+1]  <= gex ? (r_nx[j] - dsh) : r_nx[j];
                r_ny[j+1]  <= gey ? (r_ny[j] - dsh) : r_ny[j];
                r_qx[j+1]  <= r_qx[j] | (QW'(gex) << (QW - 1 - j));
                r_qy[j+1]  <= r_qy[j] | (QW'(gey) << (QW - 1 - j));
                r_den[j+1] <= r_den[j];
                r_dpl[j+1] <= r_dpl[j];
            end
        end
    end

    // thickness times unit vector: t in Q17
    logic signed [QW:0]   s2_ux;
    logic signed [QW:0]   s2_uy;
    logic signed [TW-1:0] s2_tx;
    logic signed [TW-1:0] s2_ty;

    assign s2_ux = r_dpl[QW][P_DX+DW-1] ? -$signed({1'b0, r_qx[QW]}) : $signed({1'b0, r_qx[QW]});
    assign s2_uy = r_dpl[QW][P_DY+DW-1] ? -$signed({1'b0, r_qy[QW]}) : $signed({1'b0, r_qy[QW]});
    assign s2_tx = TW'($signed({1'b0, i_thick})) * TW'(s2_ux);
    assign s2_ty = TW'($signed({1'b0, i_thick})) * TW'(s2_uy);

    logic signed [TW-1:0] r_tx;
    logic signed [TW-1:0] r_ty;
    logic [PLW-1:0]       r_mpl;
    logic                 r_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx  <= s2_tx;
            r_ty  <= s2_ty;
            r_mpl <= r_dpl[QW];
        end
    end

    // corners in Q17, rounded half away from zero
    function automatic logic signed [PW-1:0] rnd_q17(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        logic [SW-1:0] r;
        m = v[SW-1] ? $unsigned(-v) : $unsigned(v);
        r = (m + (SW'(1) << (SH - 1))) >> SH;
        rnd_q17 = v[SW-1] ? -$signed(PW'(r)) : $signed(PW'(r));
    endfunction

    logic signed [SW-1:0] s3_ax;
    logic signed [SW-1:0] s3_ay;
    logic signed [SW-1:0] s3_bx;
    logic signed [SW-1:0] s3_by;
    logic signed [SW-1:0] s3_tx;
    logic signed [SW-1:0] s3_ty;
    logic signed [SW-1:0] s3_h;
    logic signed [SW-1:0] s3_cx [0:3];
    logic signed [SW-1:0] s3_cy [0:3];

    assign s3_ax = SW'($signed(r_mpl[P_AX+CW-1:P_AX])) <<< SH;
    assign s3_ay = SW'($signed(r_mpl[P_AY+CW-1:P_AY])) <<< SH;
    assign s3_bx = SW'($signed(r_mpl[P_BX+CW-1:P_BX])) <<< SH;
    assign s3_by = SW'($signed(r_mpl[P_BY+CW-1:P_BY])) <<< SH;
    assign s3_tx = SW'(r_tx);
    assign s3_ty = SW'(r_ty);
    assign s3_h  = $signed(SW'(i_thick)) <<< (SH - 1);

    always_comb begin
        if (r_mpl[0]) begin
            // coincident endpoints: square of half the thickness
            s3_cx[0] = s3_ax - s3_h;  s3_cy[0] = s3_ay - s3_h;
            s3_cx[1] = s3_ax + s3_h;  s3_cy[1] = s3_ay - s3_h;
            s3_cx[2] = s3_ax - s3_h;  s3_cy[2] = s3_ay + s3_h;
            s3_cx[3] = s3_ax + s3_h;  s3_cy[3] = s3_ay + s3_h;
        end else begin
            s3_cx[0] = s3_ax - s3_tx - s3_ty;  s3_cy[0] = s3_ay - s3_ty + s3_tx;
            s3_cx[1] = s3_bx + s3_tx - s3_ty;  s3_cy[1] = s3_by + s3_ty + s3_tx;
            s3_cx[2] = s3_ax - s3_tx + s3_ty;  s3_cy[2] = s3_ay - s3_ty - s3_tx;
            s3_cx[3] = s3_bx + s3_tx + s3_ty;  s3_cy[3] = s3_by + s3_ty - s3_tx;
        end
    end

    logic signed [PW-1:0] r_px [0:3];
    logic signed [PW-1:0] r_py [0:3];
    logic                 r_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (en) begin
            r_rv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_px[c] <= rnd_q17(s3_cx[c]);
                r_py[c] <= rnd_q17(s3_cy[c]);
            end
        end
    end

    // bounding-box minimum and offsets
    logic signed [PW-1:0] s4_mx01;
    logic signed [PW-1:0] s4_mx23;
    logic signed [PW-1:0] s4_my01;
    logic signed [PW-1:0] s4_my23;
    logic signed [PW-1:0] s4_mx;
    logic signed [PW-1:0] s4_my;
    logic [OW-1:0]        s4_ox [0:3];
    logic [OW-1:0]        s4_oy [0:3];

    assign s4_mx01 = (r_px[1] < r_px[0]) ? r_px[1] : r_px[0];
    assign s4_mx23 = (r_px[3] < r_px[2]) ? r_px[3] : r_px[2];
    assign s4_my01 = (r_py[1] < r_py[0]) ? r_py[1] : r_py[0];
    assign s4_my23 = (r_py[3] < r_py[2]) ? r_py[3] : r_py[2];
    assign s4_mx   = (s4_mx23 < s4_mx01) ? s4_mx23 : s4_mx01;
    assign s4_my   = (s4_my23 < s4_my01) ? s4_my23 : s4_my01;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s4_ox[c] = OW'($unsigned(r_px[c] - s4_mx)) << OFFSET_FRAC_BITS;
            s4_oy[c] = OW'($unsigned(r_py[c] - s4_my)) << OFFSET_FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_origin_x   <= (CW+1)'(s4_mx);
            o_origin_y   <= (CW+1)'(s4_my);
            o_corner0_dx <= s4_ox[0];
            o_corner0_dy <= s4_oy[0];
            o_corner1_dx <= s4_ox[1];
            o_corner1_dy <= s4_oy[1];
            o_corner2_dx <= s4_ox[2];
            o_corner2_dy <= s4_oy[2];
            o_corner3_dx <= s4_ox[3];
            o_corner3_dy <= s4_oy[3];
        end
    end
endmodule

// File: sv/thick_segment_quad_unit.sv
// top level of the thick segment quad unit
// Expands each line segment into a four-corner quad of the configured stroke
// thickness and reports the bounding-box minimum plus each corner's Q8 offset.
// One segment is taken every clock while the queue is not full. The square-root
// pipeline (one root bit per stage) and then the restoring divider pipeline
// (one quotient bit per stage) form the unit vector used for each quad. A
// four-entry queue sits between the classifying front end and the arithmetic
// back end; the whole back end holds while a finished result is stalled, and
// the queue absorbs segments meanwhile. Thickness is written through
// i_cfg_we/i_cfg_data and resets to 1; the user must write it only while no
// transaction is in flight, as the block does not enforce this.
module thick_segment_quad_unit import tsq_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int OFFSET_FRAC_BITS = OFFSET_FRAC_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [THICK_W-1:0]                     i_cfg_data,
    // segment channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [COORD_WIDTH-1:0]          i_start_x,
    input  logic signed [COORD_WIDTH-1:0]          i_start_y,
    input  logic signed [COORD_WIDTH-1:0]          i_end_x,
    input  logic signed [COORD_WIDTH-1:0]          i_end_y,
    // quad channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [COORD_WIDTH:0]            o_origin_x,
    output logic signed [COORD_WIDTH:0]            o_origin_y,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner0_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner0_dy,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner1_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner1_dy,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner2_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner2_dy,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner3_dx,
    output logic [COORD_WIDTH+OFFSET_FRAC_BITS:0]  o_corner3_dy
);
    localparam int PLW = 6 * COORD_WIDTH + 3;

    // stroke thickness register
    logic [THICK_W-1:0] r_thick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thick <= THICK_RESET;
        end else if (i_cfg_we) begin
            r_thick <= i_cfg_data;
        end
    end

    // front end: differences and coincident-point flag
    logic [PLW-1:0] front_item;

    tsq_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_item    (front_item)
    );

    // decoupling queue: the segment side stalls only when it is full
    logic           q_push;
    logic           q_pop;
    logic [PLW-1:0] q_item;
    t_q_status      q_status;

    assign o_stall = q_status.full;
    assign q_push  = i_valid && !q_status.full;

    tsq_queue #(
        .WIDTH (PLW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (front_item),
        .i_pop    (q_pop),
        .o_data   (q_item),
        .o_status (q_status)
    );

    // back end: length, unit vector, corners, offsets
    tsq_back #(
        .COORD_WIDTH      (COORD_WIDTH),
        .OFFSET_FRAC_BITS (OFFSET_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_q_status   (q_status),
        .o_pop        (q_pop),
        .i_thick      (r_thick),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_origin_x   (o_origin_x),
        .o_origin_y   (o_origin_y),
        .o_corner0_dx (o_corner0_dx),
        .o_corner0_dy (o_corner0_dy),
        .o_corner1_dx (o_corner1_dx),
        .o_corner1_dy (o_corner1_dy),
        .o_corner2_dx (o_corner2_dx),
        .o_corner2_dy (o_corner2_dy),
        .o_corner3_dx (o_corner3_dx),
        .o_corner3_dy (o_corner3_dy)
    );

    // queue cannot be full and empty at once
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    // back end must not pull from the queue while the result is held
    a_hold_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !q_pop)
        else $error("queue popped while result stalled");

    // never pop an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !q_pop)
        else $error("pop from empty queue");
endmodule
